// File: sv/pwufd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwufd_pkg
// Types and constants of the pulse width frame decoder.
// ----------------------------------------------------------------------------
package pwufd_pkg;

	localparam int PULSE_W     = 16;
	localparam int HALF_W      = 8;
	localparam int CFG_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int UNIT_W      = 4;
	localparam int HIST_W      = 32;
	localparam int CHAR_BITS_W = 10;
	localparam int BIT_CNT_W   = 4;
	localparam int SUM_W       = 9;
	localparam int THR_W       = 10;
	localparam int BYTE_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_UNIT_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_TOLERANCE = 2'd1;

	localparam logic [CFG_W-1:0] UNIT_WIDTH_RST     = 6'd19;
	localparam logic [CFG_W-1:0] UNIT_TOLERANCE_RST = 6'd6;

	localparam logic [11:0]          START_HI   = 12'hA21;
	localparam logic [15:0]          START_LO   = 16'h1141;
	localparam logic [15:0]          ABORT_PAT  = 16'h00AA;
	localparam logic [BYTE_W-1:0]    CHAR_CR    = 8'h0D;
	localparam logic [BIT_CNT_W-1:0] CHAR_BITS  = 4'd10;
	localparam logic [UNIT_W-1:0]    UNIT_MIN   = 4'd1;
	localparam logic [UNIT_W-1:0]    UNIT_LAST  = 4'd9;
	localparam logic [UNIT_W-1:0]    UNIT_MAX   = 4'd10;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_QUANT  = 6'b000010,
		ST_SHIFT  = 6'b000100,
		ST_DRD    = 6'b001000,
		ST_DLD    = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/pwufd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwufd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pwufd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: sv/pulse_width_uart_frame_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_uart_frame_decoder_core
// Quantises pulse widths to bit units, spots start and abort patterns, and
// shifts units into a uart character register; a carriage return sends
// the buffered frame out.
//
// channel   dir  beat contents
// s_axis    in   tdata[15:0] pulse_width
// m_axis    out  tdata[7:0] frame_byte, tlast frame_last
// cfg       in   cfg_index register, cfg_data[5:0] value
//
// a pulse is quantised by 1..9 compares on one shared adder and comparator, then
// shifted in one unit at a time while a frame is open (1..10 units)
// a carriage return drains the buffered bytes, each read from the frame ram
// s_axis_tready is high only between pulses; m_axis stalls hold the drain
// after reset no frame is open and the registers hold 19 and 6
// ----------------------------------------------------------------------------
module pulse_width_uart_frame_decoder_core
	import pwufd_pkg::*;
#(
	parameter int FRAME_BYTES = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [PULSE_W-1:0]   s_axis_tdata,  // [15:0] pulse_width
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [BYTE_W-1:0]    m_axis_tdata,  // [7:0] frame_byte
	output logic                      m_axis_tlast,  // frame_last
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data      // [5:0] register value
);

	localparam int AW  = $clog2(FRAME_BYTES);
	localparam int BCW = $clog2(FRAME_BYTES + 1);
	localparam logic [BCW-1:0] FRAME_FULL = BCW'(FRAME_BYTES);

	state_t                 state_q;
	logic [CFG_W-1:0]       uw_q;
	logic [CFG_W-1:0]       tol_q;
	logic [HIST_W-1:0]      history_q;
	logic                   frame_open_q;
	logic                   line_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [CHAR_BITS_W-1:0] shift_q;
	logic [BCW-1:0]         byte_cnt_q;
	logic [SUM_W-1:0]       w_q;
	logic [THR_W-1:0]       acc_q;
	logic [UNIT_W-1:0]      k_q;
	logic [UNIT_W-1:0]      rem_q;
	logic                   was_open_q;
	logic [AW-1:0]          rd_idx_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_last_q;

	logic [HALF_W-1:0]      half;
	logic                   below;
	logic [CHAR_BITS_W-1:0] shift_nx;
	logic [BIT_CNT_W-1:0]   bit_cnt_inc;
	logic                   char_done;
	logic [BYTE_W-1:0]      byte_nx;
	logic [BCW-1:0]         byte_cnt_inc;
	logic                   ram_we;
	logic                   ram_re;
	logic [BYTE_W-1:0]      ram_rdata;
	logic                   out_free;
	logic                   out_load;
	logic                   rd_last;
	logic                   start_hit;
	logic                   abort_hit;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	assign half         = (s_axis_tdata[PULSE_W-1:HALF_W+1] != '0) ? '1
	                    : s_axis_tdata[HALF_W:1];
	assign below        = ({1'b0, w_q} < acc_q);
	assign shift_nx     = {shift_q[CHAR_BITS_W-2:0], line_q};
	assign bit_cnt_inc  = bit_cnt_q + BIT_CNT_W'(1);
	assign char_done    = (bit_cnt_inc == CHAR_BITS);
	assign byte_nx      = reverse8(shift_nx[BYTE_W:1]);
	assign byte_cnt_inc = byte_cnt_q + BCW'(1);
	assign ram_we       = (state_q == ST_SHIFT) && char_done && frame_open_q;
	assign ram_re       = (state_q == ST_DRD);
	assign out_free     = !out_valid_q || m_axis_tready;
	assign out_load     = (state_q == ST_DLD) && out_free;
	assign rd_last      = ((BCW'(rd_idx_q) + BCW'(1)) == byte_cnt_q);
	assign start_hit    = (history_q[27:16] == START_HI) && (history_q[15:0] == START_LO);
	assign abort_hit    = (history_q[15:0] == ABORT_PAT);

	pwufd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FRAME_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(byte_cnt_q[AW-1:0]),
		.wdata(byte_nx),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uw_q  <= UNIT_WIDTH_RST;
			tol_q <= UNIT_TOLERANCE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_UNIT_WIDTH:     uw_q  <= cfg_data;
				REG_UNIT_TOLERANCE: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			history_q    <= '0;
			frame_open_q <= 1'b0;
			line_q       <= 1'b0;
			bit_cnt_q    <= '0;
			shift_q      <= '0;
			byte_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_QUANT;
					end
				end
				ST_QUANT: begin
					if (below || k_q == UNIT_LAST) begin
						history_q <= {history_q[HIST_W-UNIT_W-1:0],
						              below ? k_q : UNIT_MAX};
						state_q   <= frame_open_q ? ST_SHIFT : ST_FINISH;
					end
				end
				ST_SHIFT: begin
					shift_q <= shift_nx;
					if (char_done) begin
						bit_cnt_q <= '0;
					end else begin
						bit_cnt_q <= bit_cnt_inc;
					end
					if (char_done && frame_open_q) begin
						byte_cnt_q <= byte_cnt_inc;
						if (byte_nx == CHAR_CR || byte_cnt_inc >= FRAME_FULL) begin
							frame_open_q <= 1'b0;
						end
					end
					if (char_done && frame_open_q && byte_nx == CHAR_CR) begin
						state_q <= ST_DRD;
					end else if (rem_q == UNIT_MIN) begin
						state_q <= ST_FINISH;
					end
				end
				ST_DRD: begin
					state_q <= ST_DLD;
				end
				ST_DLD: begin
					if (out_free) begin
						if (!rd_last) begin
							state_q <= ST_DRD;
						end else if (rem_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					if (start_hit) begin
						line_q <= 1'b0;
					end else if (was_open_q) begin
						line_q <= ~line_q;
					end
					if (start_hit) begin
						frame_open_q <= !abort_hit;
						bit_cnt_q    <= '0;
						shift_q      <= '0;
						byte_cnt_q   <= '0;
					end else if (abort_hit) begin
						frame_open_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath of the shared quantiser, unit counter and drain
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				w_q   <= SUM_W'(half) + SUM_W'(tol_q);
				acc_q <= {3'b000, uw_q, 1'b0};
				k_q   <= UNIT_MIN;
			end
			ST_QUANT: begin
				acc_q      <= acc_q + THR_W'(uw_q);
				k_q        <= k_q + UNIT_W'(1);
				rem_q      <= below ? k_q : UNIT_MAX;
				was_open_q <= frame_open_q;
			end
			ST_SHIFT: begin
				rem_q    <= rem_q - UNIT_W'(1);
				rd_idx_q <= '0;
			end
			ST_DLD: begin
				if (out_free) begin
					out_byte_q <= ram_rdata;
					out_last_q <= rd_last;
					rd_idx_q   <= rd_idx_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < CHAR_BITS) else $error("bit counter out of range");
	a_byte_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= FRAME_FULL) else $error("byte counter beyond frame size");
	a_drain_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRD || state_q == ST_DLD) |-> !frame_open_q)
		else $error("frame open during drain");
	a_shift_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> rem_q != '0) else $error("shift with no units left");
	a_open_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && frame_open_q) |-> byte_cnt_q < FRAME_FULL)
		else $error("open frame with full buffer");
`endif

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse width frame decoder. Pulse widths are
// generated from uart bit streams (start pattern, bytes, carriage return)
// under several unit width and tolerance settings, mixed with broken
// frames, restarts, buffer overflow and line noise. A behavioural decoder
// kept in the bench predicts every output beat, and the monitor compares
// byte and last flag of each beat in order.
// ----------------------------------------------------------------------------
module tb;
	import pwufd_pkg::*;

	localparam int FRAME_BYTES   = 32;
	localparam int NUM_ITEMS     = 330;
	localparam int HOLD_CYCLES   = 500;
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int MAX_REPORTS   = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum {FR_SHORT, FR_RESTART, FR_BROKEN, FR_FULL, FR_OVERFLOW} frame_style_t;
	typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_beat_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [PULSE_W-1:0]   s_axis_tdata  = '0;  // [15:0] pulse_width
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]    m_axis_tdata;        // [7:0] frame_byte
	logic                 m_axis_tlast;        // frame_last
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;

	// stimulus side
	logic [PULSE_W-1:0] pulses_to_send[$];
	bit                 line_bits[$];
	logic [CFG_W-1:0]   gen_uw;
	logic [CFG_W-1:0]   gen_tol;
	bit                 gen_ok;
	int                 n_queued   = 0;
	int                 n_settings = 0;
	int                 hold_req   = 0;

	// decoder prediction
	logic [CFG_W-1:0]       prd_uw     = UNIT_WIDTH_RST;
	logic [CFG_W-1:0]       prd_tol    = UNIT_TOLERANCE_RST;
	logic [HIST_W-1:0]      unit_hist  = '0;
	bit                     rx_open    = 1'b0;
	logic                   rx_level   = 1'b0;
	int                     bit_cnt    = 0;
	logic [CHAR_BITS_W-1:0] char_bits  = '0;
	int                     byte_cnt   = 0;
	logic [BYTE_W-1:0]      frame_buf[FRAME_BYTES];
	frame_beat_t            pending_bytes[$];

	int n_errors     = 0;
	int n_pulses_in  = 0;
	int n_bytes_out  = 0;
	int n_frames_out = 0;
	int n_reg_writes = 0;
	int cycle_cnt    = 0;

	int       burst_left = 0;
	int       gap_left   = 0;
	int       hold_done  = 0;
	int       hold_left  = 0;
	int       mode_left  = 0;
	int       rx_tick    = 0;
	rx_mode_t rx_mode    = RX_OPEN;

	pulse_width_uart_frame_decoder_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// halve, saturate, then count units against the signed thresholds
	function automatic logic [UNIT_W-1:0] units_of(input logic [PULSE_W-1:0] p,
			input logic [CFG_W-1:0] uw, input logic [CFG_W-1:0] tol);
		int half;
		int lim;
		half = int'(p >> 1);
		if (half > 255) half = 255;
		for (int k = 2; k <= 10; k++) begin
			lim = int'(uw) * k - int'(tol);
			if (half < lim) return UNIT_W'(k - 1);
		end
		return UNIT_MAX;
	endfunction

	task automatic decode_pulse(input logic [PULSE_W-1:0] p);
		logic [UNIT_W-1:0] u;
		logic [BYTE_W-1:0] b;
		frame_beat_t       fb;
		u = units_of(p, prd_uw, prd_tol);
		unit_hist = {unit_hist[HIST_W-UNIT_W-1:0], u};
		if (rx_open) begin
			for (int i = 0; i < int'(u); i++) begin
				char_bits = {char_bits[CHAR_BITS_W-2:0], rx_level};
				bit_cnt++;
				if (bit_cnt >= int'(CHAR_BITS)) begin
					bit_cnt -= int'(CHAR_BITS);
					if (rx_open) begin
						for (int k = 0; k < BYTE_W; k++) b[k] = char_bits[8-k];
						if (byte_cnt < FRAME_BYTES) frame_buf[byte_cnt] = b;
						byte_cnt++;
						if (b == CHAR_CR) begin
							for (int j = 0; j < byte_cnt && j < FRAME_BYTES; j++) begin
								fb.data = frame_buf[j];
								fb.last = (j + 1 == byte_cnt);
								pending_bytes.push_back(fb);
							end
							rx_open = 1'b0;
						end else if (byte_cnt >= FRAME_BYTES) begin
							rx_open = 1'b0;
						end
					end
				end
			end
			rx_level = ~rx_level;
		end
		if (unit_hist[27:16] == START_HI && unit_hist[15:0] == START_LO) begin
			rx_open   = 1'b1;
			rx_level  = 1'b0;
			bit_cnt   = 0;
			char_bits = '0;
			byte_cnt  = 0;
		end
		if (unit_hist[15:0] == ABORT_PAT) rx_open = 1'b0;
	endtask

	// monitor: registers, pulses in, frame bytes out
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				n_reg_writes++;
				if (cfg_index == REG_UNIT_WIDTH) prd_uw = cfg_data;
				else if (cfg_index == REG_UNIT_TOLERANCE) prd_tol = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n_pulses_in++;
				decode_pulse(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_bytes.size() == 0) begin
					if (n_errors < MAX_REPORTS)
						$display("%0t unexpected beat: expected none, actual byte %02h last %0b",
							$time, m_axis_tdata, m_axis_tlast);
					n_errors++;
				end else begin
					want = pending_bytes.pop_front();
					n_bytes_out++;
					if (want.last) n_frames_out++;
					if (m_axis_tdata !== want.data) begin
						if (n_errors < MAX_REPORTS)
							$display("%0t frame_byte mismatch: expected %02h actual %02h",
								$time, want.data, m_axis_tdata);
						n_errors++;
					end
					if (m_axis_tlast !== want.last) begin
						if (n_errors < MAX_REPORTS)
							$display("%0t frame_last mismatch: expected %0b actual %0b",
								$time, want.last, m_axis_tlast);
						n_errors++;
					end
				end
			end
		end
	end

	// pulse sender: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			burst_left    <= 0;
			gap_left      <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left      <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pulses_to_send.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pulses_to_send.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// byte receiver: own stall pattern, plus a long hold-off once a frame is due
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_done != hold_req && pending_bytes.size() > 0) begin
			hold_done     <= hold_req;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 1;
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= $urandom_range(0, 1);
				default:   m_axis_tready <= (rx_tick % 4 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic bit all_units_reachable();
		logic [UNIT_MAX:0] seen;
		seen = '0;
		for (int h = 0; h < 256; h++) seen[units_of(PULSE_W'(h * 2), gen_uw, gen_tol)] = 1'b1;
		return &seen[UNIT_MAX:UNIT_MIN];
	endfunction

	function automatic logic [PULSE_W-1:0] pulse_for(input int u);
		int cand[$];
		int w;
		for (int h = 0; h < 256; h++)
			if (units_of(PULSE_W'(h * 2), gen_uw, gen_tol) == u) cand.push_back(h);
		if (cand.size() == 0) return PULSE_W'($urandom_range(0, 65535));
		w = cand[$urandom_range(0, cand.size() - 1)];
		if (w == 255) return PULSE_W'($urandom_range(510, 65535));
		return PULSE_W'(w * 2 + $urandom_range(0, 1));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte(input bit few_edges);
		logic [BYTE_W-1:0] b;
		if (few_edges && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				2:       b = 8'hF0;
				default: b = 8'h0F;
			endcase
		end else begin
			b = BYTE_W'($urandom_range(0, 255));
		end
		if (b == CHAR_CR) b = b ^ 8'h01;
		return b;
	endfunction

	task automatic queue_pulse(input logic [PULSE_W-1:0] p);
		pulses_to_send.push_back(p);
		n_queued++;
	endtask

	task automatic send_unit(input int u);
		queue_pulse(pulse_for(u));
	endtask

	task automatic send_start();
		logic [27:0] pat;
		pat = {START_HI, START_LO};
		for (int i = 6; i >= 0; i--) send_unit(int'(pat[i*4 +: 4]));
	endtask

	// start bit, data lsb first, stop bit
	task automatic add_byte(input logic [BYTE_W-1:0] b);
		line_bits.push_back(1'b0);
		for (int k = 0; k < BYTE_W; k++) line_bits.push_back(b[k]);
		line_bits.push_back(1'b1);
	endtask

	// one pulse per run of equal line level; optionally stretch the tail or spoil a run
	task automatic send_line(input bit stretch_tail, input bit spoil);
		int runs[$];
		int r;
		int last;
		r = 1;
		for (int i = 1; i < line_bits.size(); i++) begin
			if (line_bits[i] == line_bits[i-1]) begin
				r++;
			end else begin
				runs.push_back(r);
				r = 1;
			end
		end
		runs.push_back(r);
		last = runs.size() - 1;
		if (spoil) runs[$urandom_range(0, last)] = $urandom_range(1, 10);
		if (stretch_tail) runs[last] += $urandom_range(0, 10 - runs[last]);
		foreach (runs[i]) send_unit(runs[i]);
		line_bits.delete();
	endtask

	task automatic gen_frame(input frame_style_t style);
		int nbytes;
		bit few_edges;
		few_edges = (style == FR_FULL || style == FR_OVERFLOW);
		send_start();
		if (style == FR_RESTART) begin
			repeat ($urandom_range(1, 3)) add_byte(pick_byte(1'b0));
			send_line(1'b0, 1'b0);
			send_start();
		end
		case (style)
			FR_FULL:     nbytes = FRAME_BYTES;
			FR_OVERFLOW: nbytes = FRAME_BYTES + 1;
			default:     nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
			                                                  : $urandom_range(1, 5);
		endcase
		for (int n = 1; n < nbytes; n++) add_byte(pick_byte(few_edges));
		add_byte(CHAR_CR);
		send_line($urandom_range(0, 1), style == FR_BROKEN);
	endtask

	task automatic send_noise(input int n);
		repeat (n) begin
			if ($urandom_range(0, 1)) queue_pulse(PULSE_W'($urandom_range(0, 65535)));
			else send_unit($urandom_range(1, 10));
		end
	endtask

	task automatic fill(input int budget);
		int stop;
		stop = n_queued + budget;
		while (n_queued < stop) begin
			if (gen_ok && $urandom_range(0, 9) < 8) begin
				case ($urandom_range(0, 7))
					0:       gen_frame(FR_RESTART);
					1:       gen_frame(FR_BROKEN);
					default: gen_frame(FR_SHORT);
				endcase
			end else begin
				send_noise($urandom_range(1, 5));
			end
		end
	endtask

	task automatic wait_quiet();
		do @(negedge clk);
		while (pulses_to_send.size() != 0 || s_axis_tvalid || pending_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup_phase(input logic [CFG_W-1:0] uw, input logic [CFG_W-1:0] tol);
		wait_quiet();
		write_reg(REG_UNIT_WIDTH, uw);
		write_reg(REG_UNIT_TOLERANCE, tol);
		gen_uw  = uw;
		gen_tol = tol;
		gen_ok  = all_units_reachable();
		n_settings++;
		@(negedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: saturated pulses hit the abort pattern, then a short frame
		gen_uw  = UNIT_WIDTH_RST;
		gen_tol = UNIT_TOLERANCE_RST;
		gen_ok  = all_units_reachable();
		n_settings++;
		queue_pulse(16'hFFFF);
		queue_pulse(16'hFFFF);
		queue_pulse(16'h0000);
		send_start();
		add_byte(8'h41);
		add_byte(CHAR_CR);
		send_line(1'b1, 1'b0);

		setup_phase(6'd1, 6'd0);
		fill(20);

		// full frame drained against a long receiver hold-off
		setup_phase(6'd25, 6'd0);
		hold_req++;
		gen_frame(FR_FULL);
		fill(10);

		setup_phase(6'd13, 6'd20);
		gen_frame(FR_OVERFLOW);
		fill(10);

		setup_phase(6'd63, 6'd63);
		fill(12);
		setup_phase(6'd0, 6'd0);
		write_reg(REG_SPARE_2, 6'h2A);
		write_reg(REG_SPARE_3, 6'h15);
		@(negedge clk);
		fill(8);
		setup_phase(6'd1, 6'd63);
		fill(8);
		setup_phase(6'd63, 6'd0);
		fill(10);

		while (n_queued < NUM_ITEMS) begin
			setup_phase(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(0, 63)));
			fill(30);
		end

		wait_quiet();
		$display("covered %0d pulses over %0d unit settings; %0d frames, %0d bytes checked",
			n_pulses_in, n_settings, n_frames_out, n_bytes_out);
		if (n_errors == 0 && pending_bytes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
